// ----- sv/totq_pkg.sv -----
// ----------------------------------------------------------------------------
// totq_pkg
// Types and constants shared by the tick-ordered timer queue.
// ----------------------------------------------------------------------------
package totq_pkg;

  localparam int TICK_W  = 32;
  localparam int ID_W    = 8;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD         = 2'd0,
    MODE_POP_EXPIRED = 2'd1,
    MODE_POP         = 2'd2,
    MODE_PEEK        = 2'd3
  } mode_t;

  // entry travelling down the row of cells during an insert
  typedef struct packed {
    logic              valid;
    logic              forced;
    logic [TICK_W-1:0] tick;
    logic [ID_W-1:0]   id;
  } tok_t;

  typedef struct packed {
    logic occupied;
    logic shift_left;
  } cell_ctl_t;

  // wrap-aware order: a is earlier than b when a - b is negative
  function automatic logic tick_before(input logic [TICK_W-1:0] a,
                                       input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] diff;
    diff = a - b;
    return diff[TICK_W-1];
  endfunction

endpackage

// ----- sv/totq_in_if.sv -----
// ----------------------------------------------------------------------------
// totq_in_if
// Request channel of the timer queue: one operation per transfer.
// ----------------------------------------------------------------------------
interface totq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  item_id;
  logic [31:0] tick_value;

  modport source (output valid, output mode, output item_id, output tick_value,
                  input ready);
  modport sink   (input valid, input mode, input item_id, input tick_value,
                  output ready);
endinterface

// ----- sv/totq_out_if.sv -----
// ----------------------------------------------------------------------------
// totq_out_if
// Response channel of the timer queue: one result per transfer.
// ----------------------------------------------------------------------------
interface totq_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  out_id;
  logic [31:0] out_tick;
  logic        queue_empty;
  logic        overflow;
  logic [4:0]  entry_count;

  modport source (output valid, output found, output out_id, output out_tick,
                  output queue_empty, output overflow, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input out_id, input out_tick,
                  input queue_empty, input overflow, input entry_count,
                  output ready);
endinterface

// ----- sv/totq_cell.sv -----
// ----------------------------------------------------------------------------
// totq_cell
// One slot of the sorted row: holds an entry, takes an inserted entry from
// its left neighbour and hands the displaced one on to the right.
// ----------------------------------------------------------------------------
module totq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  totq_pkg::cell_ctl_t       ctl,
  input  totq_pkg::tok_t            tok_in,
  input  logic [totq_pkg::TICK_W-1:0] right_tick,
  input  logic [totq_pkg::ID_W-1:0]   right_id,
  output totq_pkg::tok_t            tok_out,
  output logic [totq_pkg::TICK_W-1:0] tick,
  output logic [totq_pkg::ID_W-1:0]   id
);
  import totq_pkg::*;

  logic place;

  // once an entry has been displaced every later cell must take one
  assign place = tok_in.forced || !ctl.occupied || tick_before(tok_in.tick, tick);

  always_ff @(posedge clk) begin
    if (ctl.shift_left) begin
      tick <= right_tick;
      id   <= right_id;
    end else if (tok_in.valid && place) begin
      tick <= tok_in.tick;
      id   <= tok_in.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (tok_in.valid) begin
      if (place) begin
        tok_out.valid  <= ctl.occupied;
        tok_out.forced <= 1'b1;
        tok_out.tick   <= tick;
        tok_out.id     <= id;
      end else begin
        tok_out <= tok_in;
      end
    end else begin
      tok_out.valid <= 1'b0;
    end
  end

endmodule

// ----- sv/tick_ordered_timer_queue.sv -----
// ----------------------------------------------------------------------------
// tick_ordered_timer_queue
// Sorted timer queue built as a row of cells ordered by wrap-aware expiry.
// ----------------------------------------------------------------------------
// Holds up to DEPTH timers (8-bit id, 32-bit expiry tick) in a row of cells,
// head in cell 0. Pop, pop-if-expired, peek and an add to a full queue finish
// without going busy: the result is registered at the transfer edge. An add
// sends the new entry down the row one cell per cycle, and the queue stays
// busy while it ripples past the entries already held. One operation is in
// progress at a time. Entries with equal ticks leave in arrival order.
module tick_ordered_timer_queue #(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  totq_in_if.sink     request,
  totq_out_if.source  response
);
  import totq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_after;
  logic              busy;
  logic [IDX_W-1:0]  step;
  tok_t              inj;
  tok_t              tok_chain [DEPTH+1];
  logic [TICK_W-1:0] cell_tick [DEPTH];
  logic [ID_W-1:0]   cell_id   [DEPTH];

  mode_t             mode;
  logic              accept;
  logic              head_valid;
  logic              full;
  logic              expired;
  logic              take;
  logic              shift_left;
  logic              start_add;
  logic              done;
  logic [TICK_W-1:0] head_diff;

  logic              out_valid;
  logic              out_found;
  logic [ID_W-1:0]   out_id;
  logic [TICK_W-1:0] out_tick;
  logic              out_empty;
  logic              out_overflow;
  logic [COUNT_W-1:0] out_count;

  assign mode       = mode_t'(request.mode);
  assign request.ready = !busy && (!out_valid || response.ready);
  assign accept     = request.valid && request.ready;
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));
  assign head_diff  = cell_tick[0] - request.tick_value;
  assign expired    = (head_diff == '0) || head_diff[TICK_W-1];
  assign done       = busy && (step == count[IDX_W-1:0]);

  always_comb begin
    unique case (mode)
      MODE_ADD:         take = 1'b0;
      MODE_POP_EXPIRED: take = head_valid && expired;
      MODE_POP:         take = head_valid;
      MODE_PEEK:        take = head_valid;
      default:          take = 1'b0;
    endcase
  end

  assign shift_left  = accept && take && (mode != MODE_PEEK);
  assign start_add   = accept && (mode == MODE_ADD) && !full;
  assign count_after = shift_left ? count - CNT_W'(1) : count;

  assign tok_chain[0] = inj;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [TICK_W-1:0] r_tick;
    logic [ID_W-1:0]   r_id;

    assign ctl.occupied   = (count > CNT_W'(i));
    assign ctl.shift_left = shift_left;

    if (i < DEPTH - 1) begin : g_mid
      assign r_tick = cell_tick[i+1];
      assign r_id   = cell_id[i+1];
    end else begin : g_end
      assign r_tick = cell_tick[i];
      assign r_id   = cell_id[i];
    end

    totq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .tok_in     (tok_chain[i]),
      .right_tick (r_tick),
      .right_id   (r_id),
      .tok_out    (tok_chain[i+1]),
      .tick       (cell_tick[i]),
      .id         (cell_id[i])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      step      <= '0;
      inj       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((accept && !start_add) || done) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      if (start_add) begin
        inj.valid  <= 1'b1;
        inj.forced <= 1'b0;
        inj.tick   <= request.tick_value;
        inj.id     <= request.item_id;
        busy       <= 1'b1;
        step       <= '0;
      end else begin
        inj.valid <= 1'b0;
        if (accept) begin
          count <= count_after;
        end
      end
      if (busy) begin
        step <= step + IDX_W'(1);
      end
      // add complete: the entry count grows by one
      if (done) begin
        busy      <= 1'b0;
        count     <= count + CNT_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (done) begin
      out_found    <= 1'b0;
      out_id       <= '0;
      out_tick     <= '0;
      out_empty    <= 1'b0;
      out_overflow <= 1'b0;
      out_count    <= COUNT_W'(count + CNT_W'(1));
    end else if (accept && !start_add) begin
      out_found    <= take;
      out_id       <= take ? cell_id[0] : '0;
      out_tick     <= take ? cell_tick[0] : '0;
      out_empty    <= (count_after == '0);
      out_overflow <= (mode == MODE_ADD);
      out_count    <= COUNT_W'(count_after);
    end
  end

  assign response.valid       = out_valid;
  assign response.found       = out_found;
  assign response.out_id      = out_id;
  assign response.out_tick    = out_tick;
  assign response.queue_empty = out_empty;
  assign response.overflow    = out_overflow;
  assign response.entry_count = out_count;

endmodule

// ----- test/tick_ordered_timer_queue_test.sv -----
// ----------------------------------------------------------------------------
// tick_ordered_timer_queue_test
// Self-checking bench for the sorted timer queue.
// ----------------------------------------------------------------------------
// A queue of pending timer operations feeds a burst/gap driver. The sender
// pauses between chunks until every result is back. Each accepted operation
// is applied to a local sorted list, which gives the expected response. The
// monitor compares every response transfer field by field, while the
// receiver stalls on a rotating pattern.
module tick_ordered_timer_queue_test;
  import totq_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    mode_t             mode;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] tick;
  } timer_op_t;

  typedef struct {
    logic               found;
    logic [ID_W-1:0]    id;
    logic [TICK_W-1:0]  tick;
    logic               empty;
    logic               ovf;
    logic [COUNT_W-1:0] count;
  } timer_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  totq_in_if  req_ch ();
  totq_out_if rsp_ch ();

  tick_ordered_timer_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  timer_op_t  op_q[$];
  timer_res_t due_q[$];

  // local copy of the sorted list, head at index 0
  logic [TICK_W-1:0] held_tick[DEPTH];
  logic [ID_W-1:0]   held_id[DEPTH];
  int held_n  = 0;

  int errors  = 0;
  int n_add   = 0;
  int n_ovf   = 0;
  int n_taken = 0;
  int n_miss  = 0;
  int peak    = 0;

  logic        took       = 1'b0;
  int          burst_left = 0;
  int          gap_left   = 0;
  logic [15:0] stall_pat  = '1;
  int          pat_age    = 0;

  function automatic timer_res_t apply_op(timer_op_t op);
    timer_res_t r;
    int pos;
    logic [TICK_W-1:0] d;
    r = '{default: '0};
    if (op.mode == MODE_ADD) begin
      if (held_n >= DEPTH) begin
        r.ovf = 1'b1;
        n_ovf++;
      end else begin
        // goes after every entry that is not later, so equal ticks stay in order
        pos = 0;
        while (pos < held_n) begin
          d = op.tick - held_tick[pos];
          if (d[TICK_W-1]) break;
          pos++;
        end
        for (int i = held_n; i > pos; i--) begin
          held_tick[i] = held_tick[i-1];
          held_id[i]   = held_id[i-1];
        end
        held_tick[pos] = op.tick;
        held_id[pos]   = op.id;
        held_n++;
        n_add++;
      end
    end else if (held_n > 0) begin
      d = held_tick[0] - op.tick;
      if (op.mode != MODE_POP_EXPIRED || d == '0 || d[TICK_W-1]) begin
        r.found = 1'b1;
        r.id    = held_id[0];
        r.tick  = held_tick[0];
        if (op.mode != MODE_PEEK) begin
          for (int i = 1; i < held_n; i++) begin
            held_tick[i-1] = held_tick[i];
            held_id[i-1]   = held_id[i];
          end
          held_n--;
        end
        n_taken++;
      end else begin
        n_miss++;
      end
    end
    r.empty = (held_n == 0);
    r.count = held_n[COUNT_W-1:0];
    if (held_n > peak) peak = held_n;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic push_op(mode_t mode, logic [ID_W-1:0] id, logic [TICK_W-1:0] tick);
    timer_op_t op;
    op.mode = mode;
    op.id   = id;
    op.tick = tick;
    op_q.push_back(op);
  endtask

  // hold the sender off until nothing is queued, in flight or outstanding
  task automatic drain();
    while (op_q.size() != 0 || req_ch.valid || due_q.size() != 0) @(negedge clk);
  endtask

  // sender: bursts of random length, random gaps in between
  always @(negedge clk) begin
    timer_op_t op;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (op_q.size() > 0) begin
        op = op_q.pop_front();
        req_ch.mode       <= op.mode;
        req_ch.item_id    <= op.id;
        req_ch.tick_value <= op.tick;
        req_ch.valid      <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 39);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, renewed now and then
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom() | 1);
        pat_age   = $urandom_range(16, 96);
      end else begin
        pat_age--;
      end
      rsp_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // monitor: check responses, predict on every request transfer
  always @(posedge clk) begin
    timer_res_t want;
    timer_op_t  seen;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_q.size() == 0) begin
          report("response with nothing outstanding", 32'(rsp_ch.out_id), 0);
        end else begin
          want = due_q.pop_front();
          if (rsp_ch.found !== want.found)
            report("found", 32'(rsp_ch.found), 32'(want.found));
          if (rsp_ch.out_id !== want.id)
            report("out_id", 32'(rsp_ch.out_id), 32'(want.id));
          if (rsp_ch.out_tick !== want.tick) report("out_tick", rsp_ch.out_tick, want.tick);
          if (rsp_ch.queue_empty !== want.empty)
            report("queue_empty", 32'(rsp_ch.queue_empty), 32'(want.empty));
          if (rsp_ch.overflow !== want.ovf)
            report("overflow", 32'(rsp_ch.overflow), 32'(want.ovf));
          if (rsp_ch.entry_count !== want.count)
            report("entry_count", 32'(rsp_ch.entry_count), 32'(want.count));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.mode = mode_t'(req_ch.mode);
        seen.id   = req_ch.item_id;
        seen.tick = req_ch.tick_value;
        due_q.push_back(apply_op(seen));
      end
    end
  end

  initial begin
    logic [TICK_W-1:0] now;
    logic [TICK_W-1:0] tk;
    int p_add;
    int sel;
    mode_t md;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_ADD;
    req_ch.item_id    = '0;
    req_ch.tick_value = '0;
    rsp_ch.ready      = 1'b0;

    // empty queue: every read-type operation reports not found
    push_op(MODE_PEEK, 8'h00, 32'h0000_0000);
    push_op(MODE_POP, 8'hff, 32'hffff_ffff);
    push_op(MODE_POP_EXPIRED, 8'h5a, 32'hffff_ffff);
    // wrap order: 0 lands after ffffffff, equal ticks keep arrival order
    push_op(MODE_ADD, 8'hff, 32'hffff_ffff);
    push_op(MODE_ADD, 8'h00, 32'h0000_0000);
    push_op(MODE_ADD, 8'h01, 32'hffff_ffff);
    push_op(MODE_PEEK, 8'h00, 32'h0000_0000);
    push_op(MODE_POP_EXPIRED, 8'h00, 32'hffff_fffe);   // head still in the future
    push_op(MODE_POP_EXPIRED, 8'h00, 32'hffff_ffff);   // due exactly now
    for (int k = 0; k < 14; k++)
      push_op(MODE_ADD, 8'(8'h10 + k), 32'(32'h10 * (k % 4)));
    push_op(MODE_ADD, 8'hee, 32'h0000_0005);           // full, dropped
    push_op(MODE_POP_EXPIRED, 8'h00, 32'h7fff_ffff);   // difference of most negative value
    push_op(MODE_POP, 8'h00, 32'h0000_0000);

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    drain();

    // random part, in chunks with the sender held off in between
    now   = 32'hffff_fc00;
    p_add = 50;
    for (int chunk = 0; chunk < 5; chunk++) begin
      for (int k = 0; k < 100; k++) begin
        if (k % 50 == 0) p_add = 20 + 30 * $urandom_range(0, 2);
        now = now + $urandom_range(0, 20);
        if ($urandom_range(0, 99) < p_add) begin
          md  = MODE_ADD;
          sel = $urandom_range(0, 15);
          if (sel == 0) tk = $urandom();
          else if (sel < 4) tk = now + $urandom_range(0, 3);
          else tk = now + $urandom_range(0, 300);
        end else begin
          sel = $urandom_range(0, 3);
          md  = (sel < 2) ? MODE_POP_EXPIRED : (sel == 2) ? MODE_POP : MODE_PEEK;
          tk  = (md == MODE_POP_EXPIRED) ? now + $urandom_range(0, 100) - 50 : $urandom();
        end
        push_op(md, 8'($urandom_range(0, 255)), tk);
      end
      drain();
    end

    repeat (40) @(negedge clk);
    $display("%0d entries added, %0d adds dropped on a full queue, %0d heads popped or peeked",
             n_add, n_ovf, n_taken);
    $display("%0d expiry checks found the head not yet due, deepest queue %0d of %0d",
             n_miss, peak, DEPTH);
    if (errors == 0 && due_q.size() == 0) begin
      $display("PASS tick_ordered_timer_queue");
    end else begin
      $display("FAIL tick_ordered_timer_queue");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL tick_ordered_timer_queue");
    $finish;
  end

endmodule
